/* rtl/sdc_pkg.sv */
// Shared types, constants and the CRC7 step of the SD SPI command block.
`default_nettype none
package sdc_pkg;

	// Result kinds as seen on the output channel
	localparam logic [1:0] KIND_TX   = 2'd0;
	localparam logic [1:0] KIND_RX   = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;

	localparam logic [7:0]  CMD_START   = 8'h40;
	localparam logic [7:0]  TIMEOUT_R1  = 8'h80;
	localparam logic [7:0]  FILL_BYTE   = 8'hFF;
	localparam logic [7:0]  CRC_POLY    = 8'h89;
	localparam logic [11:0] TRY_RESET   = 12'h800;

	// Queue between classifier and sequencer; depth is a power of two
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// One queued job: a whole command frame, or one ready-made result
	typedef struct packed {
		logic        is_frame;
		logic [1:0]  kind;
		logic [7:0]  r1;
		logic [31:0] word;   // argument for a frame job
		logic [5:0]  cmd;
	} sdc_entry_t;

	// Fold one byte into the shifted-form CRC7 register
	function automatic logic [7:0] crc7_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			if (c[7])
				c = c ^ CRC_POLY;
			c = {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage
`default_nettype wire

/* rtl/sdc_front.sv */
// Front end: accepts items, tracks the transaction phase and queues jobs.
`default_nettype none
module sdc_front #(
	parameter int MAX_RESPONSE_BYTES = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [11:0]        cfg_wr_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               func,
	input  wire logic [5:0]         cmd_index,
	input  wire logic [31:0]        argument,
	input  wire logic [2:0]         response_length,
	input  wire logic [7:0]         rx_data,
	input  wire logic               q_ready,
	output logic                    q_push,
	output sdc_pkg::sdc_entry_t     q_entry
);

	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_WAIT    = 2'd1;
	localparam logic [1:0] PH_COLLECT = 2'd2;
	localparam logic [1:0] PH_CRC     = 2'd3;
	localparam logic [2:0] MAX_LEN    = 3'(MAX_RESPONSE_BYTES);

	logic [11:0] try_limit_q;
	logic [1:0]  phase_q;
	logic [11:0] tries_left_q;
	logic [2:0]  bytes_remaining_q;
	logic [2:0]  pending_len_q;
	logic [7:0]  saved_r1_q;
	logic [31:0] collected_q;
	logic        timed_out_q;

	logic        accept;
	logic [11:0] tries_dec;
	logic [2:0]  len_sat;
	logic [2:0]  bytes_dec;

	assign in_ready  = q_ready;
	assign accept    = in_valid && in_ready;
	assign tries_dec = (func ? tries_left_q : try_limit_q) - 12'd1;
	assign len_sat   = (response_length > MAX_LEN) ? MAX_LEN : response_length;
	assign bytes_dec = bytes_remaining_q - 3'd1;

	// A receive byte while idle produces nothing
	assign q_push = accept && !(func && (phase_q == PH_IDLE));

	always_comb begin
		q_entry          = '0;
		q_entry.cmd      = cmd_index;
		if (!func) begin
			q_entry.is_frame = 1'b1;
			q_entry.kind     = sdc_pkg::KIND_TX;
			q_entry.word     = argument;
		end else if (phase_q == PH_CRC) begin
			q_entry.kind = sdc_pkg::KIND_DONE;
			q_entry.r1   = saved_r1_q;
			q_entry.word = timed_out_q ? 32'd0 : collected_q;
		end else begin
			q_entry.kind = sdc_pkg::KIND_RX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			try_limit_q       <= sdc_pkg::TRY_RESET;
			phase_q           <= PH_IDLE;
			tries_left_q      <= '0;
			bytes_remaining_q <= '0;
			pending_len_q     <= '0;
			saved_r1_q        <= sdc_pkg::TIMEOUT_R1;
			collected_q       <= '0;
			timed_out_q       <= 1'b0;
		end else begin
			if (cfg_wr_en)
				try_limit_q <= cfg_wr_data;
			if (accept && !func) begin
				// start abandons any running transaction
				pending_len_q     <= len_sat;
				bytes_remaining_q <= '0;
				collected_q       <= '0;
				saved_r1_q        <= sdc_pkg::TIMEOUT_R1;
				tries_left_q      <= tries_dec;
				if (tries_dec == 12'd0) begin
					timed_out_q <= 1'b1;
					phase_q     <= PH_CRC;
				end else begin
					timed_out_q <= 1'b0;
					phase_q     <= PH_WAIT;
				end
			end else if (accept) begin
				case (phase_q)
					PH_WAIT: begin
						tries_left_q <= tries_dec;
						if (tries_dec == 12'd0) begin
							timed_out_q <= 1'b1;
							saved_r1_q  <= sdc_pkg::TIMEOUT_R1;
							collected_q <= '0;
							phase_q     <= PH_CRC;
						end else if (!rx_data[7]) begin
							saved_r1_q        <= rx_data;
							bytes_remaining_q <= pending_len_q;
							phase_q <= (pending_len_q != 3'd0) ? PH_COLLECT : PH_CRC;
						end
					end
					PH_COLLECT: begin
						collected_q       <= {collected_q[23:0], rx_data};
						bytes_remaining_q <= bytes_dec;
						if (bytes_dec == 3'd0)
							phase_q <= PH_CRC;
					end
					PH_CRC: begin
						phase_q <= PH_IDLE;
					end
					default: begin
					end
				endcase
			end
		end
	end

	a_collect_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_COLLECT |-> bytes_remaining_q != 3'd0)
		else $error("collect phase with no bytes left");

	a_timeout_r1: assert property (@(posedge clk) disable iff (!arst_n)
		timed_out_q && phase_q == PH_CRC |-> saved_r1_q == sdc_pkg::TIMEOUT_R1)
		else $error("timeout without timeout status");

endmodule
`default_nettype wire

/* rtl/sdc_queue.sv */
// Short job queue between the front end and the sequencer.
`default_nettype none
module sdc_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire sdc_pkg::sdc_entry_t push_entry,
	output logic                     push_ready,
	input  wire logic                pop,
	output logic                     head_valid,
	output sdc_pkg::sdc_entry_t      head_entry
);

	localparam int DEPTH = sdc_pkg::Q_DEPTH;
	localparam int PW    = sdc_pkg::Q_PTR_W;
	localparam int CW    = sdc_pkg::Q_CNT_W;

	sdc_pkg::sdc_entry_t slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = slot_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + PW'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CW'(1);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");

endmodule
`default_nettype wire

/* rtl/sdc_back.sv */
// Sequencer: plays queued jobs out as results into the output register.
`default_nettype none
module sdc_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                head_valid,
	input  wire sdc_pkg::sdc_entry_t head_entry,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [1:0]               kind,
	output logic [7:0]               tx_data,
	output logic                     chip_select_low,
	output logic [7:0]               r1_status,
	output logic [31:0]              response_word,
	output logic                     last
);

	localparam logic [2:0] BEAT_CMD  = 3'd0;
	localparam logic [2:0] BEAT_A3   = 3'd1;
	localparam logic [2:0] BEAT_A2   = 3'd2;
	localparam logic [2:0] BEAT_A1   = 3'd3;
	localparam logic [2:0] BEAT_A0   = 3'd4;
	localparam logic [2:0] BEAT_CRC  = 3'd5;
	localparam logic [2:0] BEAT_RECV = 3'd6;

	logic [2:0] beat_q;
	logic [7:0] crc_q;
	logic       out_valid_q;
	logic [1:0] kind_q;
	logic [7:0] tx_q;
	logic       cs_q;
	logic [7:0] r1_q;
	logic [31:0] word_q;
	logic       last_q;

	logic       load;
	logic [7:0] frame_byte;
	logic [7:0] crc_in;

	assign load = head_valid && (!out_valid_q || out_ready);
	assign pop  = load && (!head_entry.is_frame || beat_q == BEAT_RECV);

	always_comb begin
		case (beat_q)
			BEAT_CMD: frame_byte = sdc_pkg::CMD_START | {2'b00, head_entry.cmd};
			BEAT_A3:  frame_byte = head_entry.word[31:24];
			BEAT_A2:  frame_byte = head_entry.word[23:16];
			BEAT_A1:  frame_byte = head_entry.word[15:8];
			BEAT_A0:  frame_byte = head_entry.word[7:0];
			BEAT_CRC: frame_byte = crc_q | 8'h01;
			default:  frame_byte = sdc_pkg::FILL_BYTE;
		endcase
	end

	assign crc_in = (beat_q == BEAT_CMD) ? 8'd0 : crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			beat_q      <= BEAT_CMD;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (load && head_entry.is_frame)
				beat_q <= (beat_q == BEAT_RECV) ? BEAT_CMD : beat_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_entry.is_frame && beat_q < BEAT_CRC)
			crc_q <= sdc_pkg::crc7_byte(crc_in, frame_byte);
		if (load) begin
			if (head_entry.is_frame) begin
				kind_q <= (beat_q == BEAT_RECV) ? sdc_pkg::KIND_RX : sdc_pkg::KIND_TX;
				tx_q   <= frame_byte;
				cs_q   <= 1'b1;
				r1_q   <= 8'd0;
				word_q <= 32'd0;
				last_q <= (beat_q == BEAT_RECV);
			end else begin
				kind_q <= head_entry.kind;
				tx_q   <= (head_entry.kind == sdc_pkg::KIND_DONE) ? 8'd0 : sdc_pkg::FILL_BYTE;
				cs_q   <= (head_entry.kind != sdc_pkg::KIND_DONE);
				r1_q   <= head_entry.r1;
				word_q <= head_entry.word;
				last_q <= 1'b1;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign kind            = kind_q;
	assign tx_data         = tx_q;
	assign chip_select_low = cs_q;
	assign r1_status       = r1_q;
	assign response_word   = word_q;
	assign last            = last_q;

	a_beat_range: assert property (@(posedge clk) disable iff (!arst_n)
		beat_q <= BEAT_RECV)
		else $error("frame beat out of range");

	a_done_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == sdc_pkg::KIND_DONE |-> !cs_q && last_q)
		else $error("finish result must deselect and close the item");

endmodule
`default_nettype wire

/* rtl/sd_spi_command_transaction.sv */
// Top level of the SD SPI-mode command transaction block.
// Usage:
//   Input channel (in_valid/in_ready): func 0 starts a command from cmd_index,
//   argument and response_length; func 1 hands in a byte read from the card.
//   Output channel (out_valid/out_ready): one transfer per SPI action. kind 0
//   sends a frame byte, kind 1 asks for one receive exchange (tx 0xFF), kind 2
//   reports the finish with r1_status and response_word. last marks the final
//   result of each input item.
//   A start yields seven results (six frame bytes, CRC7 computed on the fly,
//   then one receive request); a received byte yields one, or none when idle.
//   cfg_wr_en/cfg_wr_data load the retry limit; write it only while idle.
// Timing:
//   First result of an item passes through the queue slot and then the output
//   register before it is valid. Receive items run one per cycle while
//   out_ready is high; a start holds the sequencer until all seven of its
//   results are loaded. The front end keeps accepting while results wait,
//   until the two-entry queue fills; in_ready then drops.
// Reset: arst_n clears phase, queue and output valid; retry limit goes to 2048.
// A stalled out_ready holds the output register and backs up the queue.
`default_nettype none
module sd_spi_command_transaction #(
	parameter int MAX_RESPONSE_BYTES = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [11:0] cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        func,
	input  wire logic [5:0]  cmd_index,
	input  wire logic [31:0] argument,
	input  wire logic [2:0]  response_length,
	input  wire logic [7:0]  rx_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [7:0]       tx_data,
	output logic             chip_select_low,
	output logic [7:0]       r1_status,
	output logic [31:0]      response_word,
	output logic             last
);

	logic                q_ready;
	logic                q_push;
	sdc_pkg::sdc_entry_t q_entry;
	logic                head_valid;
	sdc_pkg::sdc_entry_t head_entry;
	logic                q_pop;

	// Classify each transfer and advance the transaction state
	sdc_front #(
		.MAX_RESPONSE_BYTES(MAX_RESPONSE_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.cmd_index(cmd_index),
		.argument(argument),
		.response_length(response_length),
		.rx_data(rx_data),
		.q_ready(q_ready),
		.q_push(q_push),
		.q_entry(q_entry)
	);

	// Decouple the two sides
	sdc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_entry(q_entry),
		.push_ready(q_ready),
		.pop(q_pop),
		.head_valid(head_valid),
		.head_entry(head_entry)
	);

	// Expand jobs into output transfers
	sdc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_entry(head_entry),
		.pop(q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.tx_data(tx_data),
		.chip_select_low(chip_select_low),
		.r1_status(r1_status),
		.response_word(response_word),
		.last(last)
	);

endmodule
`default_nettype wire
